FILE: sv/tpc_pkg.sv
`default_nettype none

package tpc_pkg;

  localparam int CW     = 32;
  localparam int BW     = 15;
  localparam int PW     = 3;
  localparam int NLANE  = 4;
  localparam int IN_DW  = 304;
  localparam int OUT_DW = 288;

  localparam logic [CW-1:0] NEAR_Z = 32'd6554;

  localparam logic [PW-1:0] PL_LEFT   = 3'd0;
  localparam logic [PW-1:0] PL_RIGHT  = 3'd1;
  localparam logic [PW-1:0] PL_TOP    = 3'd2;
  localparam logic [PW-1:0] PL_BOTTOM = 3'd3;
  localparam logic [PW-1:0] PL_NEAR   = 3'd4;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef logic [CW-1:0] coord_t;
  typedef coord_t [2:0] vert_t;
  typedef vert_t [2:0] tri_t;
  typedef logic [1:0] idx_t;

  typedef enum logic [1:0] {
    K_PASS,
    K_ONE,
    K_TWO,
    K_NONE
  } kind_e;

  typedef struct packed {
    logic   valid;
    tri_t   vtx;
    idx_t   axis;
    coord_t lvl;
    kind_e  kind;
    idx_t   ins0;
    idx_t   ins1;
  } side_t;

  typedef struct packed {
    logic   neg;
    coord_t ou;
  } lane_t;

  typedef struct packed {
    side_t             side;
    lane_t [NLANE-1:0] lane;
  } dly_t;

endpackage

`default_nettype wire

FILE: sv/tpc_div.sv
`default_nettype none

module tpc_div #(
  parameter int QW = tpc_pkg::CW
) (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [2*QW-1:0] num_i,
  input  wire logic [QW-1:0]   den_i,
  output logic      [QW-1:0]   quo_o
);

  logic [QW-1:0] rem_q [QW];
  logic [QW-1:0] lo_q  [QW];
  logic [QW-1:0] quo_q [QW];
  logic [QW-1:0] den_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [QW-1:0] rem_p, lo_p, quo_p, den_p;
    logic [QW:0]   t;
    logic          ge;
    logic [QW:0]   diff;

    if (k == 0) begin : g_first
      assign rem_p = num_i[2*QW-1:QW];
      assign lo_p  = num_i[QW-1:0];
      assign quo_p = '0;
      assign den_p = den_i;
    end else begin : g_next
      assign rem_p = rem_q[k-1];
      assign lo_p  = lo_q[k-1];
      assign quo_p = quo_q[k-1];
      assign den_p = den_q[k-1];
    end

    always_comb begin
      t    = {rem_p, lo_p[QW-1]};
      diff = t - {1'b0, den_p};
      ge   = (t >= {1'b0, den_p});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[QW-1:0] : t[QW-1:0];
        lo_q[k]  <= {lo_p[QW-2:0], 1'b0};
        quo_q[k] <= {quo_p[QW-2:0], ge};
        den_q[k] <= den_p;
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

`default_nettype wire

FILE: sv/triangle_plane_clipper_top.sv
// Clips one triangle a beat against a single screen plane. The cut points are found by the
// 32-stage restoring divider with a matching delay line; a triangle is taken in every cycle
// unless the output is stalled or still owes the second beat of a split triangle, and a
// triangle with one vertex outside gives two result beats and so holds the input until its
// second beat is taken. Triangles with all three vertices outside give no beat at all.
`default_nettype none

module triangle_plane_clipper_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // plane_bound, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, one pad bit
  input  wire logic [tpc_pkg::IN_DW-1:0]   s_axis_tdata_i,
  // plane
  input  wire logic [tpc_pkg::PW-1:0]      s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  // out0_x, out0_y, out0_z, out1_x, out1_y, out1_z, out2_x, out2_y, out2_z
  output logic      [tpc_pkg::OUT_DW-1:0]  m_axis_tdata_o,
  // was_clipped
  output logic                             m_axis_tuser_o,
  output logic                             m_axis_tlast_o
);

  import tpc_pkg::*;

  function automatic coord_t mag33(input logic [CW:0] v);
    logic [CW:0] n;
    n = -v;
    return v[CW] ? n[CW-1:0] : v[CW-1:0];
  endfunction

  logic en;
  logic em_valid_q, em_beat_q, em_last;

  // Input register
  logic          v0_q;
  logic [PW-1:0] plane_q;
  logic [BW-1:0] bound_q;
  tri_t          tri0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      plane_q <= s_axis_tuser_i;
      bound_q <= s_axis_tdata_i[BW-1:0];
      tri0_q  <= s_axis_tdata_i[BW +: OUT_DW];
    end
  end

  // Classification
  idx_t   axis0;
  logic   known0;
  coord_t lvl0;
  logic [2:0] out0;
  logic [1:0] nout0;
  kind_e  kind0;
  idx_t   ins0_0, ins1_0, outs0_0, outs1_0;

  always_comb begin
    known0 = 1'b1;
    unique case (plane_q) inside
      PL_LEFT, PL_RIGHT:  axis0 = AX_X;
      PL_TOP, PL_BOTTOM:  axis0 = AX_Y;
      PL_NEAR:            axis0 = AX_Z;
      default: begin
        axis0  = AX_X;
        known0 = 1'b0;
      end
    endcase
    lvl0 = {1'b0, bound_q, 16'b0} + ((plane_q == PL_NEAR) ? NEAR_Z : '0);
    for (int i = 0; i < 3; i++) begin
      out0[i] = known0 && ((bound_q == '0) ?
                ($signed(tri0_q[i][axis0]) <  $signed(lvl0)) :
                ($signed(tri0_q[i][axis0]) >  $signed(lvl0)));
    end
    nout0 = {1'b0, out0[0]} + {1'b0, out0[1]} + {1'b0, out0[2]};
    unique case (nout0)
      2'd0:    kind0 = K_PASS;
      2'd1:    kind0 = K_ONE;
      2'd2:    kind0 = K_TWO;
      default: kind0 = K_NONE;
    endcase
    ins0_0  = !out0[0] ? 2'd0 : (!out0[1] ? 2'd1 : 2'd2);
    ins1_0  = !out0[0] ? (!out0[1] ? 2'd1 : 2'd2) : 2'd2;
    outs0_0 = out0[0] ? 2'd0 : (out0[1] ? 2'd1 : 2'd2);
    outs1_0 = out0[0] ? (out0[1] ? 2'd1 : 2'd2) : 2'd2;
  end

  side_t side1_q;
  idx_t  oa1_q, ia1_q, ob1_q, ib1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side1_q <= '0;
    end else if (en) begin
      side1_q.valid <= v0_q;
      side1_q.vtx   <= tri0_q;
      side1_q.axis  <= axis0;
      side1_q.lvl   <= lvl0;
      side1_q.kind  <= kind0;
      side1_q.ins0  <= ins0_0;
      side1_q.ins1  <= ins1_0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      oa1_q <= outs0_0;
      ia1_q <= ins0_0;
      ob1_q <= (kind0 == K_ONE) ? outs0_0 : outs1_0;
      ib1_q <= (kind0 == K_ONE) ? ins1_0 : ins0_0;
    end
  end

  // Edge differences
  idx_t   u0_1, u1_1;
  vert_t  ov [2];
  vert_t  iv [2];
  coord_t dum1 [NLANE];
  lane_t  lane1 [NLANE];
  coord_t dlm1 [2];
  coord_t dam1 [2];

  always_comb begin
    logic [CW:0] dl, da, du;
    logic        dln, dan;
    u0_1 = (side1_q.axis == AX_X) ? AX_Y : AX_X;
    u1_1 = (side1_q.axis == AX_Z) ? AX_Y : AX_Z;
    ov[0] = side1_q.vtx[oa1_q];
    iv[0] = side1_q.vtx[ia1_q];
    ov[1] = side1_q.vtx[ob1_q];
    iv[1] = side1_q.vtx[ib1_q];
    for (int c = 0; c < 2; c++) begin
      dl = {side1_q.lvl[CW-1], side1_q.lvl} -
           {ov[c][side1_q.axis][CW-1], ov[c][side1_q.axis]};
      da = {ov[c][side1_q.axis][CW-1], ov[c][side1_q.axis]} -
           {iv[c][side1_q.axis][CW-1], iv[c][side1_q.axis]};
      dln = dl[CW];
      dan = da[CW];
      dlm1[c] = mag33(dl);
      dam1[c] = mag33(da);
      du = {ov[c][u0_1][CW-1], ov[c][u0_1]} - {iv[c][u0_1][CW-1], iv[c][u0_1]};
      dum1[2*c]      = mag33(du);
      lane1[2*c].neg = du[CW] ^ dln ^ dan;
      lane1[2*c].ou  = ov[c][u0_1];
      du = {ov[c][u1_1][CW-1], ov[c][u1_1]} - {iv[c][u1_1][CW-1], iv[c][u1_1]};
      dum1[2*c+1]      = mag33(du);
      lane1[2*c+1].neg = du[CW] ^ dln ^ dan;
      lane1[2*c+1].ou  = ov[c][u1_1];
    end
  end

  side_t  side2_q, side3_q;
  coord_t dum2_q [NLANE];
  lane_t  lane2_q [NLANE];
  lane_t  lane3_q [NLANE];
  coord_t dlm2_q [2];
  coord_t dam2_q [2];
  logic [2*CW-1:0] prod3_q [NLANE];
  coord_t den3_q [NLANE];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side2_q <= '0;
      side3_q <= '0;
    end else if (en) begin
      side2_q <= side1_q;
      side3_q <= side2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 2; c++) begin
        dlm2_q[c] <= dlm1[c];
        dam2_q[c] <= dam1[c];
      end
      for (int l = 0; l < NLANE; l++) begin
        dum2_q[l]  <= dum1[l];
        lane2_q[l] <= lane1[l];
        prod3_q[l] <= dum2_q[l] * dlm2_q[l/2];
        den3_q[l]  <= dam2_q[l/2];
        lane3_q[l] <= lane2_q[l];
      end
    end
  end

  // Division and matching delay line
  coord_t quo [NLANE];

  for (genvar l = 0; l < NLANE; l++) begin : g_div
    tpc_div #(.QW(CW)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (prod3_q[l]),
      .den_i (den3_q[l]),
      .quo_o (quo[l])
    );
  end

  dly_t dly_q [CW];
  dly_t dly_in;

  always_comb begin
    dly_in.side = side3_q;
    for (int l = 0; l < NLANE; l++) begin
      dly_in.lane[l] = lane3_q[l];
    end
  end

  for (genvar k = 0; k < CW; k++) begin : g_dly
    if (k == 0) begin : g_head
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          dly_q[k] <= '0;
        end else if (en) begin
          dly_q[k] <= dly_in;
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          dly_q[k] <= '0;
        end else if (en) begin
          dly_q[k] <= dly_q[k-1];
        end
      end
    end
  end

  // Cut points
  dly_t   fin;
  coord_t res [NLANE];
  idx_t   u0_f, u1_f;
  vert_t  pa_d, pb_d;

  always_comb begin
    fin = dly_q[CW-1];
    for (int l = 0; l < NLANE; l++) begin
      res[l] = fin.lane[l].ou + (fin.lane[l].neg ? (~quo[l] + 1'b1) : quo[l]);
    end
    u0_f = (fin.side.axis == AX_X) ? AX_Y : AX_X;
    u1_f = (fin.side.axis == AX_Z) ? AX_Y : AX_Z;
    pa_d = '0;
    pb_d = '0;
    pa_d[fin.side.axis] = fin.side.lvl;
    pb_d[fin.side.axis] = fin.side.lvl;
    pa_d[u0_f] = res[0];
    pa_d[u1_f] = res[1];
    pb_d[u0_f] = res[2];
    pb_d[u1_f] = res[3];
  end

  // Output register; a one-outside triangle leaves in two beats
  kind_e em_kind_q;
  tri_t  em_tri_q;
  idx_t  em_ins0_q, em_ins1_q;
  vert_t em_pa_q, em_pb_q;

  assign em_last = (em_kind_q != K_ONE) || em_beat_q;
  assign en      = !em_valid_q || (m_axis_tready_i && em_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_valid_q <= 1'b0;
      em_beat_q  <= 1'b0;
    end else if (en) begin
      em_valid_q <= fin.side.valid && (fin.side.kind != K_NONE);
      em_beat_q  <= 1'b0;
    end else if (m_axis_tready_i) begin
      em_beat_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      em_kind_q <= fin.side.kind;
      em_tri_q  <= fin.side.vtx;
      em_ins0_q <= fin.side.ins0;
      em_ins1_q <= fin.side.ins1;
      em_pa_q   <= pa_d;
      em_pb_q   <= pb_d;
    end
  end

  tri_t out_tri;

  always_comb begin
    case (em_kind_q)
      K_ONE:   out_tri = em_beat_q ?
                         {em_pb_q, em_tri_q[em_ins1_q], em_pa_q} :
                         {em_tri_q[em_ins1_q], em_tri_q[em_ins0_q], em_pa_q};
      K_TWO:   out_tri = {em_tri_q[em_ins0_q], em_pb_q, em_pa_q};
      default: out_tri = em_tri_q;
    endcase
  end

  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = em_valid_q;
  assign m_axis_tdata_o  = out_tri;
  assign m_axis_tuser_o  = (em_kind_q != K_PASS);
  assign m_axis_tlast_o  = em_last;

endmodule

`default_nettype wire

FILE: sv/tpc_chk.sv
`default_nettype none

module tpc_chk (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        s_axis_tready_o,
  input wire logic                        m_axis_tvalid_o,
  input wire logic                        m_axis_tready_i,
  input wire logic [tpc_pkg::OUT_DW-1:0]  m_axis_tdata_o,
  input wire logic                        m_axis_tuser_o,
  input wire logic                        m_axis_tlast_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  a_first_is_clipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> m_axis_tuser_o)
    else $error("unclipped beat not marked last");

  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=>
      m_axis_tvalid_o && m_axis_tlast_o && m_axis_tuser_o)
    else $error("second beat of a split triangle missing");

endmodule

bind triangle_plane_clipper_top tpc_chk u_tpc_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire
